### design/shelfa_pkg.sv
package shelfa_pkg;

    // field widths
    localparam int DIM_W = 13;
    localparam int POS_W = 12;
    localparam int KEY_W = 19;
    localparam int CUR_W = 14;
    localparam int TOP_W = 14;
    localparam int SUM_W = 15;

    // packing constants
    localparam logic [SUM_W-1:0] GUTTER      = 15'd1;
    localparam logic [TOP_W-1:0] TOP_Y_MAX   = 14'h3fff;
    localparam logic [DIM_W-1:0] ATLAS_RESET = 13'd4096;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 1'b1;

    // request actions
    localparam logic ACT_PLACE = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT        = 3'd0,
        ST_PLACED     = 3'd1,
        ST_ZERO_SIZE  = 3'd2,
        ST_TOO_LARGE  = 3'd3,
        ST_ATLAS_FULL = 3'd4,
        ST_TABLE_FULL = 3'd5,
        ST_CLEARED    = 3'd6
    } status_t;

    typedef struct packed {
        logic             action;
        logic [15:0]      sprite_id;
        logic [2:0]       zoom_level;
        logic [DIM_W-1:0] rect_width;
        logic [DIM_W-1:0] rect_height;
    } req_t;

    typedef struct packed {
        logic [POS_W-1:0] loc_x;
        logic [POS_W-1:0] loc_y;
        logic [DIM_W-1:0] loc_w;
        logic [DIM_W-1:0] loc_h;
        status_t          status;
    } rsp_t;

    // one cache line: key and the placement stored under it
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] loc_x;
        logic [POS_W-1:0] loc_y;
        logic [DIM_W-1:0] loc_w;
        logic [DIM_W-1:0] loc_h;
    } entry_t;

endpackage

### design/shelfa_ram.sv
module shelfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/shelf_atlas_allocator.sv
// shelf atlas allocator: next-fit shelf packing with a placement cache
// clear and zero size skip the cache scan; the scan reads one stored key per cycle
// and stops early on a hit, else it covers every line below the fill count
// throughput: one request at a time, request side stalls until the result beat is loaded
// reset: cache empty, cursor at origin, atlas registers at 4096; the cache ram
// needs no clearing pass as lines are only trusted below the fill count
module shelf_atlas_allocator
    import shelfa_pkg::*;
#(
    parameter int CACHE_ENTRIES = 256,
    parameter int ATLAS_MAX     = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CW = $clog2(CACHE_ENTRIES + 1);
    localparam logic [CW-1:0]    CACHE_FULL = CW'(CACHE_ENTRIES);
    localparam logic [SUM_W-1:0] MAX_DIM    = SUM_W'(ATLAS_MAX);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_SCAN  = 6'b000100,
        S_SHELF = 6'b001000,
        S_FIT   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] atlas_w_reg, atlas_h_reg;
    logic [CUR_W-1:0] cursor_reg, cursor_next;
    logic [TOP_W-1:0] top_reg, top_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    scan_reg, scan_next;
    logic             pend_reg, pend_next;
    logic             rsp_valid_reg, rsp_valid_next;
    req_t             req_reg;
    rsp_t             res_reg, res_next;
    rsp_t             rsp_reg;

    logic [DIM_W-1:0] aw, ah;
    logic [KEY_W-1:0] key;
    logic             out_free;
    logic             ram_we;
    entry_t           ram_wdata, ram_rdata;
    logic [SUM_W-1:0] row_sum, shelf_sum, fit_sum;
    logic [TOP_W-1:0] shelf_sat;

    // cache ram: keys and placements side by side
    shelfa_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CACHE_ENTRIES)
    ) u_cache (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (scan_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // atlas size in use, clamped to the build limit
    assign aw = (SUM_W'(atlas_w_reg) > MAX_DIM) ? MAX_DIM[DIM_W-1:0] : atlas_w_reg;
    assign ah = (SUM_W'(atlas_h_reg) > MAX_DIM) ? MAX_DIM[DIM_W-1:0] : atlas_h_reg;

    assign key       = {req_reg.sprite_id, req_reg.zoom_level};
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // shelf arithmetic
    assign row_sum   = SUM_W'(cursor_reg) + SUM_W'(req_reg.rect_width) + GUTTER;
    assign shelf_sum = SUM_W'(top_reg) + SUM_W'(height_reg) + GUTTER;
    assign shelf_sat = (shelf_sum > SUM_W'(TOP_Y_MAX)) ? TOP_Y_MAX : shelf_sum[TOP_W-1:0];
    assign fit_sum   = SUM_W'(top_reg) + SUM_W'(req_reg.rect_height) + GUTTER;

    assign ram_wdata.key   = key;
    assign ram_wdata.loc_x = cursor_reg[POS_W-1:0];
    assign ram_wdata.loc_y = top_reg[POS_W-1:0];
    assign ram_wdata.loc_w = req_reg.rect_width;
    assign ram_wdata.loc_h = req_reg.rect_height;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        top_next       = top_reg;
        height_next    = height_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                res_next   = '0;
                scan_next  = '0;
                state_next = S_EMIT;
                if (req_reg.action == ACT_CLEAR)
                begin
                    res_next.status = ST_CLEARED;
                    count_next      = '0;
                    cursor_next     = '0;
                    top_next        = '0;
                    height_next     = '0;
                end
                else if (req_reg.rect_width == '0 || req_reg.rect_height == '0)
                begin
                    res_next.status = ST_ZERO_SIZE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // compare the line read last cycle while the next is fetched
                if (pend_reg && ram_rdata.key == key)
                begin
                    res_next.loc_x  = ram_rdata.loc_x;
                    res_next.loc_y  = ram_rdata.loc_y;
                    res_next.loc_w  = ram_rdata.loc_w;
                    res_next.loc_h  = ram_rdata.loc_h;
                    res_next.status = ST_HIT;
                    state_next      = S_EMIT;
                end
                else if (scan_reg != count_reg)
                begin
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    state_next = S_SHELF;
                end
            end
            S_SHELF:
            begin
                if (req_reg.rect_width > aw || req_reg.rect_height > ah)
                begin
                    res_next.status = ST_TOO_LARGE;
                    state_next      = S_EMIT;
                end
                else if (count_reg == CACHE_FULL)
                begin
                    res_next.status = ST_TABLE_FULL;
                    state_next      = S_EMIT;
                end
                else
                begin
                    // row overflow opens a new shelf, kept even on failure
                    if (row_sum > SUM_W'(aw))
                    begin
                        cursor_next = '0;
                        top_next    = shelf_sat;
                        height_next = '0;
                    end
                    state_next = S_FIT;
                end
            end
            S_FIT:
            begin
                state_next = S_EMIT;
                if (fit_sum > SUM_W'(ah))
                begin
                    res_next.status = ST_ATLAS_FULL;
                end
                else
                begin
                    res_next.loc_x  = cursor_reg[POS_W-1:0];
                    res_next.loc_y  = top_reg[POS_W-1:0];
                    res_next.loc_w  = req_reg.rect_width;
                    res_next.loc_h  = req_reg.rect_height;
                    res_next.status = ST_PLACED;
                    cursor_next     = row_sum[CUR_W-1:0];
                    if (req_reg.rect_height > height_reg)
                    begin
                        height_next = req_reg.rect_height;
                    end
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            atlas_w_reg   <= ATLAS_RESET;
            atlas_h_reg   <= ATLAS_RESET;
            cursor_reg    <= '0;
            top_reg       <= '0;
            height_reg    <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            top_reg       <= top_next;
            height_reg    <= height_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ATLAS_WIDTH:  atlas_w_reg <= cfg_data;
                    CFG_ATLAS_HEIGHT: atlas_h_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (state_reg == S_IDLE && req_valid)
        begin
            req_reg <= req;
        end
        if (state_reg == S_EMIT && out_free)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### dv/shelf_atlas_allocator_test.sv
`timescale 1ns / 1ps

module shelf_atlas_allocator_test;
    import shelfa_pkg::*;

    localparam int CACHE_LINES = 256;
    localparam int ATLAS_LIMIT = 4096;
    localparam int MAX_LATENCY = CACHE_LINES + 6;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        req_t                 req;
        logic                 chk;
        rsp_t                 want;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [DIM_W-1:0]     reg_val;
    } script_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    req_t                 req;
    logic                 rsp_valid;
    logic                 rsp_stall;
    rsp_t                 rsp;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    // shadow of the allocator state
    logic [DIM_W-1:0] model_atlas_w;
    logic [DIM_W-1:0] model_atlas_h;
    int               cursor_x_m;
    int               top_y_m;
    int               shelf_h_m;
    int               fill_m;
    logic [KEY_W-1:0] cache_key_m [CACHE_LINES];
    rsp_t             cache_place_m [CACHE_LINES];

    rsp_t             placements_due [$];
    logic [KEY_W-1:0] placed_keys [$];
    script_row_t      script_rows [$];
    int               mismatch_count = 0;
    int               results_seen = 0;

    shelf_atlas_allocator #(
        .CACHE_ENTRIES(CACHE_LINES),
        .ATLAS_MAX    (ATLAS_LIMIT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #12_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // next-fit shelf placement with a placement cache
    function automatic rsp_t predict_placement(input req_t r);
        rsp_t             o;
        int               aw;
        int               ah;
        int               w;
        int               h;
        int               ny;
        logic [KEY_W-1:0] key;
        o = '0;
        aw = (model_atlas_w > ATLAS_LIMIT) ? ATLAS_LIMIT : int'(model_atlas_w);
        ah = (model_atlas_h > ATLAS_LIMIT) ? ATLAS_LIMIT : int'(model_atlas_h);
        w = int'(r.rect_width);
        h = int'(r.rect_height);
        key = {r.sprite_id, r.zoom_level};
        if (r.action == ACT_CLEAR)
        begin
            cursor_x_m = 0;
            top_y_m = 0;
            shelf_h_m = 0;
            fill_m = 0;
            o.status = ST_CLEARED;
            return o;
        end
        if (w == 0 || h == 0)
        begin
            o.status = ST_ZERO_SIZE;
            return o;
        end
        // lookup comes after the zero-size check, before any check against the atlas
        for (int i = 0; i < fill_m; i++)
        begin
            if (cache_key_m[i] == key)
            begin
                o = cache_place_m[i];
                o.status = ST_HIT;
                return o;
            end
        end
        if (w > aw || h > ah)
        begin
            o.status = ST_TOO_LARGE;
            return o;
        end
        if (fill_m >= CACHE_LINES)
        begin
            o.status = ST_TABLE_FULL;
            return o;
        end
        // new shelf below the tallest rectangle; kept even if the height check fails
        if (cursor_x_m + w + int'(GUTTER) > aw)
        begin
            ny = top_y_m + shelf_h_m + int'(GUTTER);
            cursor_x_m = 0;
            top_y_m = (ny > int'(TOP_Y_MAX)) ? int'(TOP_Y_MAX) : ny;
            shelf_h_m = 0;
        end
        if (top_y_m + h + int'(GUTTER) > ah)
        begin
            o.status = ST_ATLAS_FULL;
            return o;
        end
        o.loc_x = POS_W'(cursor_x_m);
        o.loc_y = POS_W'(top_y_m);
        o.loc_w = r.rect_width;
        o.loc_h = r.rect_height;
        o.status = ST_PLACED;
        cursor_x_m = cursor_x_m + w + int'(GUTTER);
        if (h > shelf_h_m)
            shelf_h_m = h;
        cache_key_m[fill_m] = key;
        cache_place_m[fill_m] = o;
        fill_m++;
        return o;
    endfunction

    function automatic rsp_t mk_rsp(input int x, input int y, input int w, input int h,
                                    input status_t st);
        rsp_t o;
        o.loc_x = POS_W'(x);
        o.loc_y = POS_W'(y);
        o.loc_w = DIM_W'(w);
        o.loc_h = DIM_W'(h);
        o.status = st;
        return o;
    endfunction

    function automatic script_row_t row_req(input logic act, input int id, input int zoom,
                                            input int w, input int h, input logic chk,
                                            input rsp_t want);
        script_row_t s;
        s.kind = ROW_REQ;
        s.req.action = act;
        s.req.sprite_id = 16'(id);
        s.req.zoom_level = 3'(zoom);
        s.req.rect_width = DIM_W'(w);
        s.req.rect_height = DIM_W'(h);
        s.chk = chk;
        s.want = want;
        s.reg_sel = '0;
        s.reg_val = '0;
        return s;
    endfunction

    function automatic script_row_t row_cfg(input logic [CFG_IDX_W-1:0] sel, input int val);
        script_row_t s;
        s.kind = ROW_CFG;
        s.req = '0;
        s.chk = 1'b0;
        s.want = '0;
        s.reg_sel = sel;
        s.reg_val = DIM_W'(val);
        return s;
    endfunction

    // append one row to the directed table
    function automatic void add_row(input script_row_t s);
        script_rows = {script_rows, s};
    endfunction

    // mostly back to back, sometimes a short gap, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        else if (p < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // offer one request beat; called and returns at a falling edge
    task automatic send_request(input req_t r, input logic chk, input rsp_t want);
        int   gap;
        rsp_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = predict_placement(r);
        placements_due = {placements_due, (chk ? want : predicted)};
        @(negedge clk);
    endtask

    // register write once the allocator has drained
    task automatic write_atlas_reg(input logic [CFG_IDX_W-1:0] sel, input logic [DIM_W-1:0] val);
        req_valid <= 1'b0;
        while (placements_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (sel == CFG_ATLAS_WIDTH)
            model_atlas_w = val;
        else
            model_atlas_h = val;
    endtask

    // random requests: mostly fresh keys and repeats, the rest clears and junk sizes
    task automatic random_phase(input int count, input int size_cap, input int big_pct,
                                input int clear_pct, input int repeat_pct);
        req_t             r;
        int               p;
        logic [KEY_W-1:0] k;
        for (int n = 0; n < count; n++)
        begin
            r.action = ACT_PLACE;
            r.sprite_id = 16'($urandom);
            r.zoom_level = 3'($urandom);
            r.rect_width = DIM_W'($urandom_range(1, size_cap));
            r.rect_height = DIM_W'($urandom_range(1, size_cap));
            p = $urandom_range(0, 99);
            if (p < clear_pct)
            begin
                r.action = ACT_CLEAR;
                r.rect_width = DIM_W'($urandom);
                r.rect_height = DIM_W'($urandom);
            end
            else if (p < clear_pct + 4)
            begin
                if ($urandom_range(0, 1))
                    r.rect_width = '0;
                else
                    r.rect_height = '0;
            end
            else if (p < clear_pct + 8)
            begin
                r.rect_width = DIM_W'($urandom_range(0, 8191));
                r.rect_height = DIM_W'($urandom_range(0, 8191));
            end
            else if (p < clear_pct + 8 + repeat_pct && placed_keys.size() != 0)
            begin
                k = placed_keys[$urandom_range(0, placed_keys.size() - 1)];
                r.sprite_id = k[KEY_W-1:3];
                r.zoom_level = k[2:0];
            end
            else
            begin
                if ($urandom_range(0, 99) < big_pct)
                begin
                    r.rect_width = DIM_W'($urandom_range(1, ATLAS_LIMIT));
                    r.rect_height = DIM_W'($urandom_range(1, ATLAS_LIMIT));
                end
                k = {r.sprite_id, r.zoom_level};
                placed_keys = {placed_keys, k};
            end
            send_request(r, 1'b0, '0);
        end
    endtask

    task automatic flag_field(input string field, input logic [15:0] want_v,
                              input logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s expected %0d got %0d", field, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // result checker
    initial
    begin
        rsp_t got;
        rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                got = rsp;
                results_seen++;
                if (placements_due.size() == 0)
                begin
                    $error("result beat with nothing outstanding, status %0d", got.status);
                    mismatch_count++;
                end
                else
                begin
                    want = placements_due.pop_front();
                    flag_field("loc_x", 16'(want.loc_x), 16'(got.loc_x));
                    flag_field("loc_y", 16'(want.loc_y), 16'(got.loc_y));
                    flag_field("loc_w", 16'(want.loc_w), 16'(got.loc_w));
                    flag_field("loc_h", 16'(want.loc_h), 16'(got.loc_h));
                    flag_field("status", 16'(want.status), 16'(got.status));
                end
            end
        end
    end

    // result side back-pressure, with one long hold-off once traffic is flowing
    initial
    begin
        int   spell_len;
        logic spell_stall;
        logic held_long;
        int   p;
        spell_len = 0;
        spell_stall = 1'b0;
        held_long = 1'b0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_long && results_seen >= 150)
            begin
                held_long = 1'b1;
                spell_stall = 1'b1;
                spell_len = 400;
            end
            else if (spell_len == 0)
            begin
                p = $urandom_range(0, 99);
                if (p < 45)
                begin
                    spell_stall = 1'b0;
                    spell_len = $urandom_range(1, 4);
                end
                else if (p < 75)
                begin
                    spell_stall = 1'b1;
                    spell_len = $urandom_range(1, 3);
                end
                else if (p < 80)
                begin
                    spell_stall = 1'b1;
                    spell_len = $urandom_range(15, 50);
                end
                else
                begin
                    spell_stall = 1'b0;
                    spell_len = $urandom_range(30, 120);
                end
            end
            rsp_stall <= spell_stall;
            spell_len--;
        end
    end

    // stimulus
    initial
    begin
        req_t clear_req;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        model_atlas_w = ATLAS_RESET;
        model_atlas_h = ATLAS_RESET;
        cursor_x_m = 0;
        top_y_m = 0;
        shelf_h_m = 0;
        fill_m = 0;

        // directed rows
        add_row(row_req(ACT_PLACE, 1, 0, 0, 5, 1'b1,
                        mk_rsp(0, 0, 0, 0, ST_ZERO_SIZE)));
        add_row(row_req(ACT_PLACE, 1, 0, 5, 0, 1'b1,
                        mk_rsp(0, 0, 0, 0, ST_ZERO_SIZE)));
        add_row(row_req(ACT_PLACE, 2, 1, 4097, 1, 1'b1,
                        mk_rsp(0, 0, 0, 0, ST_TOO_LARGE)));
        add_row(row_req(ACT_PLACE, 3, 2, 8191, 8191, 1'b1,
                        mk_rsp(0, 0, 0, 0, ST_TOO_LARGE)));
        // full-width rectangle opens a shelf straight away
        add_row(row_req(ACT_PLACE, 0, 0, 4096, 10, 1'b0, '0));
        add_row(row_req(ACT_PLACE, 0, 0, 4096, 10, 1'b0, '0));
        add_row(row_req(ACT_CLEAR, 0, 0, 0, 0, 1'b1,
                        mk_rsp(0, 0, 0, 0, ST_CLEARED)));
        add_row(row_req(ACT_PLACE, 65535, 7, 1, 1, 1'b1,
                        mk_rsp(0, 0, 1, 1, ST_PLACED)));
        // hit returns the stored size, not the requested one
        add_row(row_req(ACT_PLACE, 65535, 7, 20, 20, 1'b0, '0));
        add_row(row_req(ACT_PLACE, 5, 3, 1, 4096, 1'b1,
                        mk_rsp(0, 0, 0, 0, ST_ATLAS_FULL)));
        // shelf advance survives the atlas-full outcome
        add_row(row_req(ACT_PLACE, 6, 4, 4095, 4095, 1'b1,
                        mk_rsp(0, 0, 0, 0, ST_ATLAS_FULL)));
        add_row(row_req(ACT_PLACE, 7, 5, 10, 10, 1'b0, '0));
        add_row(row_req(ACT_PLACE, 65535, 7, 0, 1, 1'b1,
                        mk_rsp(0, 0, 0, 0, ST_ZERO_SIZE)));
        // zero width register rejects misses, hits still served
        add_row(row_cfg(CFG_ATLAS_WIDTH, 0));
        add_row(row_req(ACT_PLACE, 8, 0, 1, 1, 1'b1,
                        mk_rsp(0, 0, 0, 0, ST_TOO_LARGE)));
        add_row(row_req(ACT_PLACE, 65535, 7, 1, 1, 1'b0, '0));
        add_row(row_cfg(CFG_ATLAS_HEIGHT, 0));
        add_row(row_cfg(CFG_ATLAS_WIDTH, 8191));
        add_row(row_req(ACT_PLACE, 8, 0, 1, 1, 1'b1,
                        mk_rsp(0, 0, 0, 0, ST_TOO_LARGE)));
        add_row(row_cfg(CFG_ATLAS_HEIGHT, 1));
        add_row(row_req(ACT_PLACE, 9, 1, 1, 1, 1'b1,
                        mk_rsp(0, 0, 0, 0, ST_ATLAS_FULL)));
        // oversized register value clamps to the atlas limit
        add_row(row_cfg(CFG_ATLAS_HEIGHT, 4096));
        add_row(row_req(ACT_PLACE, 9, 1, 4096, 1, 1'b0, '0));
        add_row(row_req(ACT_CLEAR, 65535, 7, 8191, 8191, 1'b1,
                        mk_rsp(0, 0, 0, 0, ST_CLEARED)));
        add_row(row_req(ACT_PLACE, 32768, 6, 4096, 4096, 1'b0, '0));

        // reset
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script_rows[i])
        begin
            if (script_rows[i].kind == ROW_CFG)
                write_atlas_reg(script_rows[i].reg_sel, script_rows[i].reg_val);
            else
                send_request(script_rows[i].req, script_rows[i].chk, script_rows[i].want);
        end

        // fill the cache past its capacity on the default atlas
        write_atlas_reg(CFG_ATLAS_WIDTH, ATLAS_RESET);
        clear_req = '0;
        clear_req.action = ACT_CLEAR;
        send_request(clear_req, 1'b0, '0);
        random_phase(380, 40, 0, 0, 15);

        // tight atlas: frequent shelf advances and atlas full
        write_atlas_reg(CFG_ATLAS_WIDTH, 13'd300);
        write_atlas_reg(CFG_ATLAS_HEIGHT, 13'd200);
        random_phase(60, 60, 10, 6, 35);

        // both registers above the limit
        write_atlas_reg(CFG_ATLAS_WIDTH, 13'd8191);
        write_atlas_reg(CFG_ATLAS_HEIGHT, 13'd8191);
        random_phase(60, 1500, 10, 5, 30);

        // one pixel wide atlas
        write_atlas_reg(CFG_ATLAS_WIDTH, 13'd1);
        write_atlas_reg(CFG_ATLAS_HEIGHT, ATLAS_RESET);
        random_phase(40, 30, 5, 5, 30);

        write_atlas_reg(CFG_ATLAS_WIDTH, DIM_W'($urandom_range(1, 500)));
        write_atlas_reg(CFG_ATLAS_HEIGHT, DIM_W'($urandom_range(1, 500)));
        random_phase(60, 80, 10, 6, 35);

        // drain
        req_valid <= 1'b0;
        while (placements_due.size() != 0)
            @(posedge clk);
        repeat (MAX_LATENCY + 40) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### shelf_atlas_allocator.f
design/shelfa_pkg.sv
design/shelfa_ram.sv
design/shelf_atlas_allocator.sv
dv/shelf_atlas_allocator_test.sv
